// ----- hdl/assert_macros.svh -----
// Assertion macros used by the checker file of this block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is held low.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("same-cycle property failed");

// Next-cycle implication, disabled while reset is held low.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("next-cycle property failed");

`endif

// ----- hdl/fcr_pkg.sv -----
// Shared constants and types of the framed command receiver.
`timescale 1ns / 1ps

package fcr_pkg;

    // Waypoint table geometry.
    localparam int TABLE_ENTRIES = 16;
    localparam int TABLE_IDX_W   = $clog2(TABLE_ENTRIES);

    // Command queue between the parser and the execution unit.
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
    localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

    // Frame delimiters and limits.
    localparam logic [7:0] HDR0     = 8'h15;
    localparam logic [7:0] HDR1     = 8'h79;
    localparam logic [7:0] HDR2     = 8'h78;
    localparam logic [7:0] MAX_CODE = 8'h09;
    localparam logic [7:0] TRAILER  = 8'h05;

    // Parser positions inside a frame.
    localparam logic [3:0] POS_HDR0    = 4'd0;
    localparam logic [3:0] POS_HDR1    = 4'd1;
    localparam logic [3:0] POS_HDR2    = 4'd2;
    localparam logic [3:0] POS_CODE    = 4'd3;
    localparam logic [3:0] POS_TRAILER = 4'd14;
    localparam logic [3:0] POS_INVALID = 4'd15;

    // Only payload bytes 0 to 7 are ever used; the code byte is kept as well.
    localparam int PAYLOAD_USED = 8;
    localparam int FRAME_KEPT   = PAYLOAD_USED + 1;

    // Function codes.
    localparam logic [3:0] CODE_START   = 4'd0;
    localparam logic [3:0] CODE_WP_LAST = 4'd8;
    localparam logic [3:0] CODE_MODE    = 4'd9;

    // Stream widths, padded to whole bytes.
    localparam int S_TDATA_W = 16;
    localparam int M_TDATA_W = 56;

    typedef enum logic [1:0] {
        CMD_BYTE,
        CMD_FRAME,
        CMD_READ
    } t_cmd_kind;

    // One queued command: a plain byte, a finished frame or a table read.
    typedef struct packed {
        t_cmd_kind                     kind;
        logic [3:0]                    code;
        logic [PAYLOAD_USED-1:0][7:0]  payload;
        logic [TABLE_IDX_W-1:0]        read_index;
    } t_cmd;

    // One result item before packing onto the stream.
    typedef struct packed {
        logic               frame_done;
        logic [3:0]         function_code;
        logic               start_request;
        logic [7:0]         target_point;
        logic [7:0]         task_mode;
        logic signed [15:0] entry_x;
        logic signed [15:0] entry_y;
    } t_result;

endpackage

// ----- hdl/fcr_frame_parser.sv -----
// Front part: accepts input items, tracks frame position and builds commands.
`timescale 1ns / 1ps

module fcr_frame_parser (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_valid,
    output logic                            o_ready,
    input  logic                            i_op,
    input  logic [7:0]                      i_rx_byte,
    input  logic [fcr_pkg::TABLE_IDX_W-1:0] i_read_index,
    input  logic                            i_full,
    output logic                            o_push,
    output fcr_pkg::t_cmd                   o_cmd
);

    logic [3:0] r_pos;
    logic [3:0] n_pos;
    logic [7:0] r_frame_bytes [fcr_pkg::FRAME_KEPT];
    logic       w_accept;
    logic       w_parse;

    // An item is taken whenever the queue has room.
    assign o_ready  = !i_full;
    assign w_accept = i_valid && !i_full;
    assign o_push   = w_accept;
    assign w_parse  = w_accept && !i_op;

    // Next position and the command that this item turns into.
    always_comb begin
        n_pos            = r_pos;
        o_cmd.kind       = i_op ? fcr_pkg::CMD_READ : fcr_pkg::CMD_BYTE;
        o_cmd.code       = r_frame_bytes[0][3:0];
        o_cmd.read_index = i_read_index;
        for (int i = 0; i < fcr_pkg::PAYLOAD_USED; i++) begin
            o_cmd.payload[i] = r_frame_bytes[i + 1];
        end
        unique case (r_pos)
            fcr_pkg::POS_HDR0: begin
                n_pos = (i_rx_byte == fcr_pkg::HDR0) ? fcr_pkg::POS_HDR1 : fcr_pkg::POS_HDR0;
            end
            fcr_pkg::POS_HDR1: begin
                n_pos = (i_rx_byte == fcr_pkg::HDR1) ? fcr_pkg::POS_HDR2 : fcr_pkg::POS_HDR0;
            end
            fcr_pkg::POS_HDR2: begin
                n_pos = (i_rx_byte == fcr_pkg::HDR2) ? fcr_pkg::POS_CODE : fcr_pkg::POS_HDR0;
            end
            fcr_pkg::POS_CODE: begin
                n_pos = (i_rx_byte <= fcr_pkg::MAX_CODE) ? (fcr_pkg::POS_CODE + 4'd1)
                                                         : fcr_pkg::POS_HDR0;
            end
            fcr_pkg::POS_TRAILER: begin
                n_pos = fcr_pkg::POS_HDR0;
                if (!i_op && (i_rx_byte == fcr_pkg::TRAILER)) begin
                    o_cmd.kind = fcr_pkg::CMD_FRAME;
                end
            end
            fcr_pkg::POS_INVALID: begin
                n_pos = fcr_pkg::POS_HDR0;
            end
            default: begin
                n_pos = r_pos + 4'd1;
            end
        endcase
    end

    // Position register moves only on parsed bytes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos <= fcr_pkg::POS_HDR0;
        end else if (w_parse) begin
            r_pos <= n_pos;
        end
    end

    // Capture the code byte and the payload bytes that are used later.
    always_ff @(posedge i_clk) begin
        for (int i = 0; i < fcr_pkg::FRAME_KEPT; i++) begin
            if (w_parse && (r_pos == (fcr_pkg::POS_CODE + 4'(i)))) begin
                r_frame_bytes[i] <= i_rx_byte;
            end
        end
    end

endmodule

// ----- hdl/fcr_cmd_fifo.sv -----
// Short command queue that decouples the parser from the execution unit.
`timescale 1ns / 1ps

module fcr_cmd_fifo (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  fcr_pkg::t_cmd i_cmd,
    output logic          o_full,
    input  logic          i_pop,
    output fcr_pkg::t_cmd o_cmd,
    output logic          o_empty
);

    fcr_pkg::t_cmd                 r_mem [fcr_pkg::FIFO_DEPTH];
    logic [fcr_pkg::FIFO_PTR_W-1:0] r_wr_ptr;
    logic [fcr_pkg::FIFO_PTR_W-1:0] r_rd_ptr;
    logic [fcr_pkg::FIFO_CNT_W-1:0] r_count;

    assign o_full  = (r_count == fcr_pkg::FIFO_CNT_W'(fcr_pkg::FIFO_DEPTH));
    assign o_empty = (r_count == '0);
    assign o_cmd   = r_mem[r_rd_ptr];

    // Pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (!i_push && i_pop) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    // Storage needs no reset.
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

endmodule

// ----- hdl/fcr_exec_unit.sv -----
// Back part: applies frames, serves table reads and holds the result register.
`timescale 1ns / 1ps

module fcr_exec_unit (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_empty,
    input  fcr_pkg::t_cmd    i_cmd,
    output logic             o_pop,
    output logic             o_valid,
    input  logic             i_ready,
    output fcr_pkg::t_result o_result
);

    logic [31:0]                     r_table [fcr_pkg::TABLE_ENTRIES];
    logic                            r_start;
    logic [7:0]                      r_target;
    logic [7:0]                      r_task;
    logic                            r_out_valid;
    fcr_pkg::t_result                r_result;
    logic                            n_start;
    logic [7:0]                      n_target;
    logic [7:0]                      n_task;
    fcr_pkg::t_result                n_result;
    logic                            w_take;
    logic                            w_wp_en;
    logic [fcr_pkg::TABLE_IDX_W-1:0] w_wp_even;
    logic [fcr_pkg::TABLE_IDX_W-1:0] w_wp_odd;
    logic [2:0]                      w_pair;

    // A command is taken when the result register is free or being emptied.
    assign w_take   = !i_empty && (!r_out_valid || i_ready);
    assign o_pop    = w_take;
    assign o_valid  = r_out_valid;
    assign o_result = r_result;

    // Codes 1 to 8 address the entry pair 2(code-1) and 2(code-1)+1.
    assign w_pair    = i_cmd.code[2:0] - 3'd1;
    assign w_wp_even = fcr_pkg::TABLE_IDX_W'({w_pair, 1'b0});
    assign w_wp_odd  = fcr_pkg::TABLE_IDX_W'({w_pair, 1'b1});

    // Work out the register updates and the result of the head command.
    always_comb begin
        n_start  = r_start;
        n_target = r_target;
        n_task   = r_task;
        w_wp_en  = 1'b0;
        n_result = '0;
        unique case (i_cmd.kind)
            fcr_pkg::CMD_FRAME: begin
                n_result.frame_done    = 1'b1;
                n_result.function_code = i_cmd.code;
                if (i_cmd.code == fcr_pkg::CODE_START) begin
                    if ({i_cmd.payload[0], i_cmd.payload[1]} == 16'd1) begin
                        n_start = 1'b1;
                    end
                    n_target = i_cmd.payload[2];
                end else if (i_cmd.code <= fcr_pkg::CODE_WP_LAST) begin
                    w_wp_en = 1'b1;
                end else if (i_cmd.code == fcr_pkg::CODE_MODE) begin
                    n_task = i_cmd.payload[0];
                end
            end
            fcr_pkg::CMD_READ: begin
                n_result.entry_x = r_table[i_cmd.read_index][31:16];
                n_result.entry_y = r_table[i_cmd.read_index][15:0];
            end
            fcr_pkg::CMD_BYTE: begin
                n_result.frame_done = 1'b0;
            end
            default: begin
                n_result.frame_done = 1'b0;
            end
        endcase
        n_result.start_request = n_start;
        n_result.target_point  = n_target;
        n_result.task_mode     = n_task;
    end

    // Architectural state and the output valid flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start     <= 1'b0;
            r_target    <= '0;
            r_task      <= '0;
            r_out_valid <= 1'b0;
            for (int i = 0; i < fcr_pkg::TABLE_ENTRIES; i++) begin
                r_table[i] <= '0;
            end
        end else begin
            if (w_take) begin
                r_start     <= n_start;
                r_target    <= n_target;
                r_task      <= n_task;
                r_out_valid <= 1'b1;
                if (w_wp_en) begin
                    r_table[w_wp_even] <= {i_cmd.payload[0], i_cmd.payload[1],
                                           i_cmd.payload[2], i_cmd.payload[3]};
                    r_table[w_wp_odd]  <= {i_cmd.payload[4], i_cmd.payload[5],
                                           i_cmd.payload[6], i_cmd.payload[7]};
                end
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Result payload register.
    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_result <= n_result;
        end
    end

endmodule

// ----- hdl/framed_command_receiver_unit.sv -----
// Top level of the framed command receiver.
`timescale 1ns / 1ps

// Usage:
// The slave stream carries one item per received byte or table read. tuser selects
// the operation (0 = parse the byte, 1 = read a waypoint entry); tdata holds the byte
// and the entry index. Every input item yields exactly one result item on the master
// stream, in order. tuser of a result is set when the byte completed a valid frame;
// tdata carries the function code, the current start flag, target point and task mode,
// and the x/y of the entry read (zero for parsed bytes).
// A result passes through the command queue and then the result register before it is
// valid. The block sustains one item per cycle while the master side takes every result:
// the parser feeds a four-entry command queue, and the execution unit takes one command
// per cycle into its output register when that register is free or being emptied.
// When the master side stalls, the result register holds and the queue fills; the
// slave side keeps accepting until the queue holds four commands.
// Synchronous reset clears the frame position, the start flag, the target point, the
// task mode, the whole waypoint table and the queue.
module framed_command_receiver_unit (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_s_axis_tvalid,
    output logic                          o_s_axis_tready,
    // tdata: rx_byte [7:0], read_index [11:8], zero fill [15:12]
    input  logic [fcr_pkg::S_TDATA_W-1:0] i_s_axis_tdata,
    // tuser: op [0]
    input  logic                          i_s_axis_tuser,
    output logic                          o_m_axis_tvalid,
    input  logic                          i_m_axis_tready,
    // tdata: function_code [3:0], start_request [4], target_point [12:5],
    //        task_mode [20:13], entry_x [36:21], entry_y [52:37], zero fill [55:53]
    output logic [fcr_pkg::M_TDATA_W-1:0] o_m_axis_tdata,
    // tuser: frame_done [0]
    output logic                          o_m_axis_tuser
);

    fcr_pkg::t_cmd    w_push_cmd;
    fcr_pkg::t_cmd    w_head_cmd;
    fcr_pkg::t_result w_result;
    logic             w_push;
    logic             w_pop;
    logic             w_full;
    logic             w_empty;

    fcr_frame_parser u_parser (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_s_axis_tvalid),
        .o_ready      (o_s_axis_tready),
        .i_op         (i_s_axis_tuser),
        .i_rx_byte    (i_s_axis_tdata[7:0]),
        .i_read_index (i_s_axis_tdata[11:8]),
        .i_full       (w_full),
        .o_push       (w_push),
        .o_cmd        (w_push_cmd)
    );

    fcr_cmd_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_cmd   (w_push_cmd),
        .o_full  (w_full),
        .i_pop   (w_pop),
        .o_cmd   (w_head_cmd),
        .o_empty (w_empty)
    );

    fcr_exec_unit u_exec (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_empty  (w_empty),
        .i_cmd    (w_head_cmd),
        .o_pop    (w_pop),
        .o_valid  (o_m_axis_tvalid),
        .i_ready  (i_m_axis_tready),
        .o_result (w_result)
    );

    // Pack the result item onto the master stream.
    assign o_m_axis_tuser = w_result.frame_done;
    assign o_m_axis_tdata = {3'b000,
                             w_result.entry_y,
                             w_result.entry_x,
                             w_result.task_mode,
                             w_result.target_point,
                             w_result.start_request,
                             w_result.function_code};

endmodule

// ----- hdl/fcr_port_checker.sv -----
// Port-level checks of the framed command receiver, bound to the top level.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module fcr_port_checker (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          o_m_axis_tvalid,
    input logic                          i_m_axis_tready,
    input logic [fcr_pkg::M_TDATA_W-1:0] o_m_axis_tdata,
    input logic                          o_m_axis_tuser
);

    // A stalled result holds its value.
    `ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_m_axis_tvalid && !i_m_axis_tready, o_m_axis_tvalid && $stable(o_m_axis_tdata) && $stable(o_m_axis_tuser))

    // A completed frame reports a legal function code.
    `ASSERT_IMPL(a_done_code, i_clk, i_rst_n, o_m_axis_tvalid && o_m_axis_tuser, o_m_axis_tdata[3:0] <= fcr_pkg::CODE_MODE)

    // Without a completed frame the function code reads zero.
    `ASSERT_IMPL(a_idle_code, i_clk, i_rst_n, o_m_axis_tvalid && !o_m_axis_tuser, o_m_axis_tdata[3:0] == 4'd0)

    // Once shown, the start flag stays set in every later result while the output stays valid without a break.
    `ASSERT_NEXT(a_start_sticky, i_clk, i_rst_n, o_m_axis_tvalid && o_m_axis_tdata[4], !o_m_axis_tvalid || o_m_axis_tdata[4])

endmodule

bind framed_command_receiver_unit fcr_port_checker u_port_checker (.*);
